@@ design/ipc_pkg.sv @@
package ipc_pkg;

    // field widths
    localparam int ACTION_W    = 3;
    localparam int SOIL_W      = 10;
    localparam int TIME_W      = 32;
    localparam int EVENT_W     = 3;
    localparam int THRESH_W    = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_EVALUATE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUMP_ON     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUMP_OFF    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MODE_AUTO   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MODE_MANUAL = 3'd4;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_MANUAL_START = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STOP_CMD     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_AUTO_START   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SOIL_OK_STOP = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT_STOP = 3'd5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PUMP_MS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN_INTERVAL  = 2'd2;

    // register reset values and threshold limits
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd30;
    localparam logic [THRESH_W-1:0] THRESH_MIN   = 7'd10;
    localparam logic [THRESH_W-1:0] THRESH_MAX   = 7'd80;
    localparam logic [TIME_W-1:0]   MAX_PUMP_RESET      = 32'd45000;
    localparam logic [TIME_W-1:0]   WARN_INTERVAL_RESET = 32'd30000;

    // hysteresis band and dry margin, in tenths of a percent
    localparam int SOIL_OK_BAND = 80;
    localparam int DRY_MARGIN   = 50;

    typedef struct packed {
        logic [THRESH_W-1:0] soil_threshold;
        logic [TIME_W-1:0]   max_pump_ms;
        logic [TIME_W-1:0]   warn_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SOIL_W-1:0]   soil_tenths;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic               pump_running;
        logic               auto_active;
        logic [EVENT_W-1:0] event_code;
        logic               dry_warning;
        logic               status_changed;
    } result_t;

endpackage

@@ design/ipc_cfg.sv @@
module ipc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ipc_pkg::cfg_t                    cfg
);
    import ipc_pkg::*;

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [THRESH_W-1:0] thresh_wr;

    // threshold writes outside the legal band are dropped
    assign thresh_wr = cfg_wdata[THRESH_W-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOIL_THRESHOLD: begin
                    if (thresh_wr >= THRESH_MIN && thresh_wr <= THRESH_MAX) begin
                        cfg_next.soil_threshold = thresh_wr;
                    end
                end
                REG_MAX_PUMP_MS:   cfg_next.max_pump_ms      = cfg_wdata[TIME_W-1:0];
                REG_WARN_INTERVAL: cfg_next.warn_interval_ms = cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soil_threshold   <= THRESH_RESET;
            cfg_reg.max_pump_ms      <= MAX_PUMP_RESET;
            cfg_reg.warn_interval_ms <= WARN_INTERVAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ipc_core.sv @@
module ipc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ipc_pkg::item_t   item,
    input  ipc_pkg::cfg_t    cfg,
    output ipc_pkg::result_t result
);
    import ipc_pkg::*;

    localparam int TH_W = 11;   // threshold times ten, up to 1270
    localparam int SUM_W = 12;

    logic              pump_reg;
    logic              pump_next;
    logic              auto_reg;
    logic              auto_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] warn_reg;
    logic [TIME_W-1:0] warn_next;

    logic [TH_W-1:0]   th;
    logic [TIME_W-1:0] run_time;
    logic [TIME_W-1:0] warn_age;
    logic              below_th;
    logic              soil_ok;
    logic              timed_out;
    logic              dry;
    logic [EVENT_W-1:0] event_code;
    logic              warn;
    logic              changed;

    // threshold scaled to tenths: th*8 + th*2
    assign th = {1'b0, cfg.soil_threshold, 3'b000}
              + {3'b000, cfg.soil_threshold, 1'b0};

    // compares on moisture and wrapping time differences
    assign run_time  = item.now_ms - start_reg;
    assign warn_age  = item.now_ms - warn_reg;
    assign below_th  = {1'b0, item.soil_tenths} < th;
    assign soil_ok   = {2'b00, item.soil_tenths} >= ({1'b0, th} + SUM_W'(SOIL_OK_BAND));
    assign timed_out = run_time > cfg.max_pump_ms;
    assign dry       = ({2'b00, item.soil_tenths} + SUM_W'(DRY_MARGIN)) < {1'b0, th};

    // per-action decision
    always_comb begin
        pump_next  = pump_reg;
        auto_next  = auto_reg;
        start_next = start_reg;
        warn_next  = warn_reg;
        event_code = EV_NONE;
        warn       = 1'b0;
        changed    = 1'b0;
        case (item.action)
            ACT_EVALUATE: begin
                if (auto_reg) begin
                    if (!pump_reg && below_th) begin
                        pump_next  = 1'b1;
                        start_next = item.now_ms;
                        event_code = EV_AUTO_START;
                        changed    = 1'b1;
                    end else if (pump_reg && (timed_out || soil_ok)) begin
                        pump_next  = 1'b0;
                        event_code = soil_ok ? EV_SOIL_OK_STOP : EV_TIMEOUT_STOP;
                        changed    = 1'b1;
                    end
                end
                // dry warning looks at the pump state before this tick
                if (!pump_reg && dry && (warn_age > cfg.warn_interval_ms)) begin
                    warn      = 1'b1;
                    warn_next = item.now_ms;
                end
            end
            ACT_PUMP_ON: begin
                if (!auto_reg) begin
                    pump_next  = 1'b1;
                    start_next = item.now_ms;
                    event_code = EV_MANUAL_START;
                    changed    = 1'b1;
                end
            end
            ACT_PUMP_OFF: begin
                pump_next  = 1'b0;
                event_code = EV_STOP_CMD;
                changed    = 1'b1;
            end
            ACT_MODE_AUTO: begin
                auto_next = 1'b1;
                changed   = 1'b1;
            end
            ACT_MODE_MANUAL: begin
                auto_next = 1'b0;
            end
            default: ;
        endcase
    end

    // controller state, updated as each item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pump_reg  <= 1'b0;
            auto_reg  <= 1'b1;
            start_reg <= '0;
            warn_reg  <= '0;
        end else if (advance) begin
            pump_reg  <= pump_next;
            auto_reg  <= auto_next;
            start_reg <= start_next;
            warn_reg  <= warn_next;
        end
    end

    assign result.pump_running   = pump_next;
    assign result.auto_active    = auto_next;
    assign result.event_code     = event_code;
    assign result.dry_warning    = warn;
    assign result.status_changed = changed;

endmodule

@@ design/irrigation_pump_controller.sv @@
// channel   | valid   | ready   | payload
// ----------+---------+---------+-----------------------------------------------
// input     | s_valid | s_ready | s_action, s_soil_tenths, s_now_ms
// result    | m_valid | m_ready | m_pump_running, m_auto_active, m_event_code,
//           |         |         | m_dry_warning, m_status_changed
// config    | cfg_wr_en (no ready) | cfg_index, cfg_wdata
//
// one item per cycle sustained while m_ready stays high; an item is registered in the
// input register, then in the result register; the controller state updates as the item
// moves between the two, so the next item can follow immediately
// reset (synchronous, active low) puts the pump off, auto mode, both timestamps at 0
// and the registers at their defaults; no clearing pass
// a stalled result holds the result register; the input register keeps taking one
// more item, then s_ready drops until the result moves
module irrigation_pump_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ipc_pkg::ACTION_W-1:0]      s_action,
    input  logic [ipc_pkg::SOIL_W-1:0]        s_soil_tenths,
    input  logic [ipc_pkg::TIME_W-1:0]        s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pump_running,
    output logic                              m_auto_active,
    output logic [ipc_pkg::EVENT_W-1:0]       m_event_code,
    output logic                              m_dry_warning,
    output logic                              m_status_changed,
    input  logic                              cfg_wr_en,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ipc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_xfer;

    // an item moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    ipc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.action      <= s_action;
            item_reg.soil_tenths <= s_soil_tenths;
            item_reg.now_ms      <= s_now_ms;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pump_running   = res_reg.pump_running;
    assign m_auto_active    = res_reg.auto_active;
    assign m_event_code     = res_reg.event_code;
    assign m_dry_warning    = res_reg.dry_warning;
    assign m_status_changed = res_reg.status_changed;

endmodule

@@ design/ipc_checker.sv @@
module ipc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_pump_running,
    input logic                            m_auto_active,
    input logic [ipc_pkg::EVENT_W-1:0]     m_event_code,
    input logic                            m_status_changed
);
    import ipc_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code))
        else $error("stalled result dropped or changed");

    // a start event leaves the pump running and requests publication
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == EV_AUTO_START || m_event_code == EV_MANUAL_START)
        |-> m_pump_running && m_status_changed)
        else $error("start event without running pump");

    // a stop event leaves the pump off
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == EV_STOP_CMD || m_event_code == EV_SOIL_OK_STOP
                    || m_event_code == EV_TIMEOUT_STOP)
        |-> !m_pump_running && m_status_changed)
        else $error("stop event with pump running");

    // manual starts only occur in manual mode
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_code == EV_MANUAL_START |-> !m_auto_active)
        else $error("manual start in auto mode");

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pump_running   (m_pump_running),
    .m_auto_active    (m_auto_active),
    .m_event_code     (m_event_code),
    .m_status_changed (m_status_changed)
);
